[sv/rmsd_pkg.sv]
// rmsd_pkg: shared widths, codes and the command struct for the running
// mean / standard deviation block. No dependencies.
`default_nettype none
package rmsd_pkg;

  localparam int SAMPLE_W = 16;   // Q8.8 sample, mean and std dev
  localparam int GOAL_W   = 16;
  localparam int SUM_W    = 32;   // signed Q24.8 running sum
  localparam int SQ_W     = 48;   // unsigned Q32.16 running sum of squares
  localparam int STEP_W   = 6;

  localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd32;  // |sum| / count
  localparam logic [STEP_W-1:0] SQ_STEPS   = 6'd48;  // sum_sq / count
  localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd24;  // sqrt of 48-bit variance

  localparam logic signed [SAMPLE_W-1:0] ABORT_BELOW_RESET = 16'sd1280;  // 5.0

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
  localparam logic [1:0] FUNC_PREEMPT = 2'd2;

  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_SUCCEEDED = 2'd1;
  localparam logic [1:0] ST_ABORTED   = 2'd2;
  localparam logic [1:0] ST_PREEMPTED = 2'd3;

  // command to the shared divide / square-root unit
  typedef struct packed {
    logic              start;
    logic              root;   // 1: square root, 0: divide
    logic [STEP_W-1:0] steps;
  } it_cmd_t;

endpackage
`default_nettype wire

[sv/rmsd_if.sv]
// rmsd_in_if / rmsd_out_if: valid-ready channels for input and result items.
// Depends on rmsd_pkg.
`default_nettype none
interface rmsd_in_if;
  import rmsd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic signed [SAMPLE_W-1:0] sample;
  logic [GOAL_W-1:0]          goal_count;
  modport source (output valid, func, sample, goal_count, input ready);
  modport sink   (input valid, func, sample, goal_count, output ready);
endinterface

interface rmsd_out_if;
  import rmsd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_echo;
  logic [GOAL_W-1:0]          sample_index;
  logic signed [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0]        std_dev;
  logic [1:0]                 status;
  modport source (output valid, sample_echo, sample_index, mean, std_dev, status,
                  input ready);
  modport sink   (input valid, sample_echo, sample_index, mean, std_dev, status,
                  output ready);
endinterface
`default_nettype wire

[sv/rmsd_iter.sv]
// rmsd_iter: shared shift / compare / subtract unit, one quotient or root bit
// per cycle (restoring divide or digit-by-digit square root). Uses rmsd_pkg.
`default_nettype none
module rmsd_iter #(
  parameter int DIVISOR_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rmsd_pkg::it_cmd_t          cmd,
  input  logic [rmsd_pkg::SQ_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic                       done,
  output logic [rmsd_pkg::SQ_W-1:0]  quot
);
  import rmsd_pkg::*;

  // remainder must hold divisor + 1 bit, and a 25-bit root remainder + 2 bits
  localparam int RW = ((DIVISOR_W > 25) ? DIVISOR_W : 25) + 2;

  logic [RW-1:0]        rem;
  logic [RW-1:0]        shin;
  logic [RW-1:0]        trial;
  logic [RW-1:0]        diff;
  logic                 ge;
  logic [SQ_W-1:0]      num;
  logic [DIVISOR_W-1:0] dvs;
  logic                 root;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;

  always_comb begin
    if (root) begin
      shin  = {rem[RW-3:0], num[SQ_W-1 -: 2]};
      trial = {quot[RW-3:0], 2'b01};
    end else begin
      shin  = {rem[RW-2:0], num[SQ_W-1]};
      trial = RW'(dvs);
    end
    ge   = (shin >= trial);
    diff = shin - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the last step
      done <= !cmd.start && busy && (cnt == STEP_W'(1));
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= '0;
      quot <= '0;
      num  <= dividend;
      dvs  <= divisor;
      root <= cmd.root;
    end else if (busy) begin
      rem  <= ge ? diff : shin;
      quot <= {quot[SQ_W-2:0], ge};
      num  <= root ? (num << 2) : (num << 1);
    end
  end

endmodule
`default_nettype wire

[sv/running_mean_stddev_goal.sv]
// running_mean_stddev_goal: running mean and standard deviation over a goal
// of N Q8.8 samples. Depends on rmsd_pkg, rmsd_if.sv and rmsd_iter.
//
// Channels: item (sink) carries func / sample / goal_count; result (source)
// carries sample_echo / sample_index / mean / std_dev / status. Both move an
// item on a clock edge with valid and ready high. cfg_wr_en / cfg_wr_data
// write the abort_below threshold (Q8.8, reset 5.0).
// A start item clears the count and both sums, latches the goal and arms the
// run; it leaves the sequencer idle and gives no result. A sample while armed
// updates the sums, then the shared iterative unit runs three jobs one after
// another: |sum|/count, sum_sq/count and the square root of the variance,
// with sequencing states between them, before the result register is loaded.
// A preempt skips the sum update, and when no sample was taken yet it skips
// the three jobs too and reports zero statistics.
// The shared unit retires one quotient or root bit per cycle. Only one item
// is in work at a time; item.ready is high while the sequencer is idle. The
// result register decouples the sides: a new item is accepted while an older
// result waits, and a finished item waits in the sequencer while the receiver
// stalls.
// Reset (rst, synchronous) disarms the run, zeroes the statistics, empties
// the result register and restores abort_below.
`default_nettype none
module running_mean_stddev_goal #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  rmsd_in_if.sink                           item,
  rmsd_out_if.source                        result,
  input  logic                              cfg_wr_en,
  input  logic signed [rmsd_pkg::SAMPLE_W-1:0] cfg_wr_data
);
  import rmsd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > GOAL_W) ? COUNT_WIDTH : GOAL_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_ACCUM, S_STATS, S_MEAN_WAIT, S_MSQ, S_SQ_WAIT,
    S_ROOT_GO, S_ROOT_WAIT, S_FINISH
  } state_t;

  state_t state;

  // run state
  logic                       active;
  logic [COUNT_WIDTH-1:0]     taken;
  logic signed [SUM_W-1:0]    sum;
  logic [SQ_W-1:0]            sum_sq;
  logic [GOAL_W-1:0]          goal;
  logic signed [SAMPLE_W-1:0] abort_below;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] smp;
  logic                       is_preempt;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [SAMPLE_W:0]          mean_mag;
  logic [2*SAMPLE_W+1:0]      msq;
  logic [SQ_W-1:0]            var_r;
  logic [SAMPLE_W-1:0]        sd_r;

  // shared unit
  it_cmd_t                    it_cmd;
  logic [SQ_W-1:0]            it_dividend;
  logic                       it_done;
  logic [SQ_W-1:0]            it_quot;
  logic                       it_go;

  // result register
  logic                       out_valid;
  logic                       out_load;
  logic signed [SAMPLE_W-1:0] out_echo;
  logic [GOAL_W-1:0]          out_index;
  logic signed [SAMPLE_W-1:0] out_mean;
  logic [SAMPLE_W-1:0]        out_sd;
  logic [1:0]                 out_status;

  // accumulate path: saturating sum, squared sample, saturating sum of squares
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [SQ_W:0]              sq_wide;
  logic [SQ_W-1:0]            sum_sq_next;

  // stats path
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           qm;
  logic [SAMPLE_W:0]          mag_c;
  logic signed [SAMPLE_W-1:0] mean_c;
  logic                       goal_hit;

  always_comb begin
    sum_wide = {sum[SUM_W-1], sum} + (SUM_W+1)'(smp);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
    prod        = smp * smp;
    sq_wide     = {1'b0, sum_sq} + (SQ_W+1)'(unsigned'(prod));
    sum_sq_next = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];

    sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

    // quotient magnitude -> clamped signed mean (truncation toward zero)
    qm = it_quot[SUM_W-1:0];
    if (sum[SUM_W-1]) begin
      mag_c = (qm > SUM_W'(32768)) ? 17'd32768 : qm[SAMPLE_W:0];
    end else begin
      mag_c = (qm > SUM_W'(32767)) ? 17'd32767 : qm[SAMPLE_W:0];
    end
    mean_c = sum[SUM_W-1] ? SAMPLE_W'(17'd0 - mag_c) : mag_c[SAMPLE_W-1:0];

    goal_hit = (CMP_W'(taken) == CMP_W'(goal));

    // start pulse for the shared unit, and result register load
    it_go    = (state == S_STATS && taken != '0) || (state == S_MSQ) ||
               (state == S_ROOT_GO);
    out_load = (state == S_FINISH) && (!out_valid || result.ready);
  end

  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active      <= 1'b0;
      taken       <= '0;
      sum         <= '0;
      sum_sq      <= '0;
      goal        <= '0;
      abort_below <= ABORT_BELOW_RESET;
      it_cmd      <= '0;
      out_valid   <= 1'b0;
      is_preempt  <= 1'b0;
    end else begin
      it_cmd.start <= it_go;
      if (cfg_wr_en) begin
        abort_below <= cfg_wr_data;
      end
      out_valid <= out_load || (out_valid && !result.ready);

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            if (item.func == FUNC_START) begin
              taken  <= '0;
              sum    <= '0;
              sum_sq <= '0;
              goal   <= item.goal_count;
              active <= 1'b1;
            end else if (active && item.func == FUNC_SAMPLE) begin
              smp        <= item.sample;
              is_preempt <= 1'b0;
              state      <= S_ACCUM;
            end else if (active && item.func == FUNC_PREEMPT) begin
              smp        <= '0;
              is_preempt <= 1'b1;
              active     <= 1'b0;
              state      <= S_STATS;
            end
          end
        end

        S_ACCUM: begin
          if (taken != COUNT_MAX) begin
            taken <= taken + 1'b1;
          end
          sum    <= sum_next;
          sum_sq <= sum_sq_next;
          state  <= S_STATS;
        end

        S_STATS: begin
          if (taken == '0) begin
            // preempt before any sample
            mean_r <= '0;
            sd_r   <= '0;
            state  <= S_FINISH;
          end else begin
            it_cmd.root  <= 1'b0;
            it_cmd.steps <= MEAN_STEPS;
            it_dividend  <= {sum_mag, {(SQ_W-SUM_W){1'b0}}};
            state        <= S_MEAN_WAIT;
          end
        end

        S_MEAN_WAIT: begin
          if (it_done) begin
            mean_r   <= mean_c;
            mean_mag <= mag_c;
            state    <= S_MSQ;
          end
        end

        S_MSQ: begin
          msq          <= mean_mag * mean_mag;
          it_cmd.root  <= 1'b0;
          it_cmd.steps <= SQ_STEPS;
          it_dividend  <= sum_sq;
          state        <= S_SQ_WAIT;
        end

        S_SQ_WAIT: begin
          if (it_done) begin
            // negative variance clamps to zero
            var_r <= (it_quot > SQ_W'(msq)) ? (it_quot - SQ_W'(msq)) : '0;
            state <= S_ROOT_GO;
          end
        end

        S_ROOT_GO: begin
          it_cmd.root  <= 1'b1;
          it_cmd.steps <= ROOT_STEPS;
          it_dividend  <= var_r;
          state        <= S_ROOT_WAIT;
        end

        S_ROOT_WAIT: begin
          if (it_done) begin
            sd_r  <= (|it_quot[23:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
                                             : it_quot[SAMPLE_W-1:0];
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          // wait for an empty (or draining) result register
          if (out_load) begin
            out_echo  <= smp;
            out_index <= GOAL_W'(CMP_W'(taken));
            out_mean  <= mean_r;
            out_sd    <= sd_r;
            if (is_preempt) begin
              out_status <= ST_PREEMPTED;
            end else if (goal_hit) begin
              out_status <= (mean_r < abort_below) ? ST_ABORTED : ST_SUCCEEDED;
              active     <= 1'b0;
            end else begin
              out_status <= ST_RUNNING;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  rmsd_iter #(
    .DIVISOR_W (COUNT_WIDTH)
  ) u_iter (
    .clk      (clk),
    .rst      (rst),
    .cmd      (it_cmd),
    .dividend (it_dividend),
    .divisor  (taken),
    .done     (it_done),
    .quot     (it_quot)
  );

  assign result.valid        = out_valid;
  assign result.sample_echo  = out_echo;
  assign result.sample_index = out_index;
  assign result.mean         = out_mean;
  assign result.std_dev      = out_sd;
  assign result.status       = out_status;

  // the unit only reports completion while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    it_done |-> (state == S_MEAN_WAIT || state == S_SQ_WAIT || state == S_ROOT_WAIT))
    else $error("iterative unit done outside a wait state");

  // a sample always bumps the count, so only a preempt sees an empty run
  a_empty_is_preempt: assert property (@(posedge clk) disable iff (rst)
    (state == S_STATS && taken == '0) |-> is_preempt)
    else $error("statistics requested on an empty run by a sample");

  // an accepted sample on an armed run goes to the accumulate step
  a_sample_accum: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && active && item.func == FUNC_SAMPLE) |=> state == S_ACCUM)
    else $error("accepted sample did not start accumulation");

endmodule
`default_nettype wire

[verif/rmsd_stats_checker.sv]
// rmsd_stats_checker: watches the item, result and threshold ports of the
// running mean / std dev block, predicts every result and compares it.
// Depends on rmsd_pkg and the channel interfaces in rmsd_if.sv.
`default_nettype none
module rmsd_stats_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  rmsd_in_if                                   item,
  rmsd_out_if                                  result,
  input  logic                                 cfg_wr_en,
  input  logic signed [rmsd_pkg::SAMPLE_W-1:0] cfg_wr_data,
  output int                                   mismatches,
  output int                                   waiting,
  output int                                   checked,
  output int                                   n_succeeded,
  output int                                   n_aborted,
  output int                                   n_preempted
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmsd_pkg::*;

  localparam logic [GOAL_W-1:0] COUNT_TOP = '1;
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;
  localparam longint unsigned SQ_TOP = (64'd1 << SQ_W) - 64'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] echo;
    logic [GOAL_W-1:0]          index;
    logic signed [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0]        sd;
    logic [1:0]                 status;
  } stats_result_t;

  // mirror of the block's run state
  logic                       run_armed;
  logic [GOAL_W-1:0]          run_taken;
  longint                     run_sum;
  longint unsigned            run_sq;
  logic [GOAL_W-1:0]          run_goal;
  logic signed [SAMPLE_W-1:0] abort_thr;

  stats_result_t expected_stats[$];

  // mean truncated toward zero, std dev as floor root of the clamped variance
  function automatic void calc_stats(output logic signed [SAMPLE_W-1:0] m,
                                     output logic [SAMPLE_W-1:0] sd);
    longint q;
    longint unsigned msq, ms, vr, root, trial;
    m  = '0;
    sd = '0;
    if (run_taken != 0) begin
      q = run_sum / longint'(run_taken);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      m   = q[SAMPLE_W-1:0];
      msq = q * q;
      ms  = run_sq / run_taken;
      vr  = (ms > msq) ? ms - msq : 64'd0;
      root = 0;
      for (int b = 24; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= vr) root = trial;
      end
      sd = (root > 64'd65535) ? '1 : root[SAMPLE_W-1:0];
    end
  endfunction

  always @(posedge clk) begin
    stats_result_t got, want;
    longint s;
    longint unsigned usq;
    logic signed [SAMPLE_W-1:0] m;
    logic [SAMPLE_W-1:0] sd;
    if (rst) begin
      run_armed = 1'b0;
      run_taken = '0;
      run_sum   = 0;
      run_sq    = 0;
      run_goal  = '0;
      abort_thr = ABORT_BELOW_RESET;
      expected_stats.delete();
      waiting <= 0;
    end else begin
      if (cfg_wr_en) abort_thr = cfg_wr_data;

      // results first: an item accepted on this edge cannot be answered yet
      if (result.valid && result.ready) begin
        got = '{result.sample_echo, result.sample_index, result.mean,
                result.std_dev, result.status};
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result echo=%0d idx=%0d mean=%0d sd=%0d st=%0d",
                     $realtime, $signed(got.echo), got.index, $signed(got.mean),
                     got.sd, got.status);
        end else begin
          want = expected_stats.pop_front();
          checked++;
          case (want.status)
            ST_SUCCEEDED: n_succeeded++;
            ST_ABORTED:   n_aborted++;
            ST_PREEMPTED: n_preempted++;
            default: ;
          endcase
          if (got.echo !== want.echo || got.index !== want.index ||
              got.mean !== want.mean || got.sd !== want.sd || got.status !== want.status)
          begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch exp echo=%0d idx=%0d mean=%0d sd=%0d st=%0d",
                     $realtime, $signed(want.echo), want.index, $signed(want.mean),
                     want.sd, want.status);
              $display(" | got echo=%0d idx=%0d mean=%0d sd=%0d st=%0d",
                       $signed(got.echo), got.index, $signed(got.mean), got.sd,
                       got.status);
            end
          end
        end
      end

      if (item.valid && item.ready) begin
        case (item.func)
          FUNC_START: begin
            run_taken = '0;
            run_sum   = 0;
            run_sq    = 0;
            run_goal  = item.goal_count;
            run_armed = 1'b1;
          end
          FUNC_SAMPLE: if (run_armed) begin
            s = item.sample;
            if (run_taken != COUNT_TOP) run_taken++;
            run_sum += s;
            if (run_sum > SUM_HI) run_sum = SUM_HI;
            if (run_sum < SUM_LO) run_sum = SUM_LO;
            usq = s * s;
            run_sq = (run_sq > SQ_TOP - usq) ? SQ_TOP : run_sq + usq;
            calc_stats(m, sd);
            want = '{item.sample, run_taken, m, sd, ST_RUNNING};
            if (run_taken == run_goal) begin
              want.status = (m < abort_thr) ? ST_ABORTED : ST_SUCCEEDED;
              run_armed   = 1'b0;
            end
            expected_stats.push_back(want);
          end
          FUNC_PREEMPT: if (run_armed) begin
            calc_stats(m, sd);
            expected_stats.push_back('{'0, run_taken, m, sd, ST_PREEMPTED});
            run_armed = 1'b0;
          end
          default: ;
        endcase
      end
      waiting <= expected_stats.size();
    end
  end

endmodule
`default_nettype wire

[verif/tb_top.sv]
// tb_top: stimulus and verdict for running_mean_stddev_goal. Drives the item
// and threshold ports, stalls the result port; rmsd_stats_checker does the checking.
// Depends on rmsd_pkg, rmsd_if.sv, the block and rmsd_stats_checker.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmsd_pkg::*;

  // func code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 100;
  // a sample works through three jobs in the shared divide / root unit
  localparam int SETTLE_CYCLES   = 200;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT     = 4000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic signed [SAMPLE_W-1:0] cfg_wr_data;

  always #1 clk = ~clk;

  rmsd_in_if  item_ch ();
  rmsd_out_if result_ch ();

  running_mean_stddev_goal u_top (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  int mismatches, waiting, checked, n_succeeded, n_aborted, n_preempted;

  rmsd_stats_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .waiting     (waiting),
    .checked     (checked),
    .n_succeeded (n_succeeded),
    .n_aborted   (n_aborted),
    .n_preempted (n_preempted)
  );

  // idling knobs, percent of cycles; changed per phase
  int tx_idle_pct;
  int rx_stall_pct;
  // each bump asks the receiver for one long hold-off
  int hold_reqs;
  int n_offered;
  // threshold currently programmed, used to aim samples near the decision
  logic signed [SAMPLE_W-1:0] cur_thr;

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request.
  // During the hold the sender keeps offering, so the sequencer and the
  // result register both fill and item.ready drops.
  // ---------------------------------------------------------------------
  initial begin
    int seen_reqs;
    int hold_left;
    seen_reqs = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen_reqs) begin
        seen_reqs = hold_reqs;
        hold_left = RX_HOLD_CYCLES;
      end
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long with no item moving on either side means a hang.
  // ---------------------------------------------------------------------
  int quiet;
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("running_mean_stddev_goal test failed");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns on the
  // edge where it is taken. valid stays high so back-to-back items flow.
  task automatic offer(input logic [1:0] f, input logic signed [SAMPLE_W-1:0] s,
                       input logic [GOAL_W-1:0] g);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.func       <= f;
    item_ch.sample     <= s;
    item_ch.goal_count <= g;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    n_offered++;
  endtask

  // Stop offering and wait until every predicted result has come out.
  // The first edge lets the checker count an item taken on this step.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Sample mix: full range, near the abort threshold, small, and extremes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom());
    if (r < 70) begin
      v = int'(cur_thr) + $urandom_range(0, 1024) - 512;
      return v[SAMPLE_W-1:0];
    end
    if (r < 90) begin
      v = $urandom_range(0, 2047) - 1024;
      return v[SAMPLE_W-1:0];
    end
    return r[0] ? 16'sh7FFF : 16'sh8000;
  endfunction

  // One random sequence: mostly a well-formed run (start, samples, maybe a
  // preempt), sometimes a lone noise item of any func.
  task automatic random_run();
    int roll;
    int planned;
    int cut;
    logic [GOAL_W-1:0] goal;
    roll = $urandom_range(99);
    if (roll < 20) begin
      offer(2'($urandom_range(3)), 16'($urandom()), 16'($urandom()));
    end else begin
      roll = $urandom_range(99);
      if (roll < 75)      goal = 16'($urandom_range(1, 8));
      else if (roll < 85) goal = '0;  // never ends by count
      else if (roll < 92) goal = 16'($urandom_range(9, 40));
      else                goal = 16'($urandom());
      offer(FUNC_START, 16'($urandom()), goal);
      planned = (goal == 0 || goal > 40) ? $urandom_range(1, 8) : int'(goal);
      cut = ($urandom_range(99) < 15) ? $urandom_range(0, planned - 1) : -1;
      for (int i = 0; i < planned; i++) begin
        if (i == cut) begin
          offer(FUNC_PREEMPT, 16'($urandom()), 16'($urandom()));
          break;
        end
        offer(FUNC_SAMPLE, pick_sample(), 16'($urandom()));
      end
      // open-ended goals usually get preempted, else the next start drops them
      if (cut < 0 && planned != int'(goal) && $urandom_range(99) < 70)
        offer(FUNC_PREEMPT, 16'($urandom()), 16'($urandom()));
      // stray sample after the run: ignored unless an open-ended run is still armed
      if ($urandom_range(99) < 10)
        offer(FUNC_SAMPLE, pick_sample(), 16'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------
  initial begin
    int base;
    bit hold_done;
    bit drain_done;
    logic signed [SAMPLE_W-1:0] thr;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_reqs    = 0;
    n_offered    = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    cur_thr      = ABORT_BELOW_RESET;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.func       <= FUNC_START;
    item_ch.sample     <= '0;
    item_ch.goal_count <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items, with the threshold left at its reset value of 5.0.
    // Nothing is armed yet: sample, preempt and the unused func are ignored.
    offer(FUNC_SAMPLE, 16'sh0100, '0);
    offer(FUNC_PREEMPT, '0, '0);
    offer(FUNC_UNUSED, 16'sh7FFF, '1);
    // three-sample run over both sample extremes, mean far below: aborted
    offer(FUNC_START, '0, 16'd3);
    offer(FUNC_SAMPLE, 16'sh7FFF, '0);
    offer(FUNC_SAMPLE, 16'sh8000, '0);
    offer(FUNC_SAMPLE, 16'sh0100, '0);
    // mean exactly on the threshold succeeds, one LSB under aborts
    offer(FUNC_START, '0, 16'd1);
    offer(FUNC_SAMPLE, ABORT_BELOW_RESET, '0);
    offer(FUNC_START, '0, 16'd1);
    offer(FUNC_SAMPLE, ABORT_BELOW_RESET - 16'sd1, '0);
    // goal of zero never ends by count; unused func ignored while armed
    offer(FUNC_START, '0, 16'd0);
    offer(FUNC_SAMPLE, -16'sd1, '0);
    offer(FUNC_UNUSED, '0, '0);
    offer(FUNC_PREEMPT, '0, '0);
    // restart while armed drops the old run; preempt after one sample
    offer(FUNC_START, '0, 16'd5);
    offer(FUNC_START, '0, 16'd2);
    offer(FUNC_SAMPLE, 16'sh7FFF, '0);
    offer(FUNC_PREEMPT, '0, '0);
    // preempt before any sample: all statistics zero
    offer(FUNC_START, '0, 16'd4);
    offer(FUNC_PREEMPT, '0, '0);
    // largest goal, most negative samples, then preempt
    offer(FUNC_START, '0, 16'hFFFF);
    offer(FUNC_SAMPLE, 16'sh8000, '0);
    offer(FUNC_SAMPLE, 16'sh8000, '0);
    offer(FUNC_PREEMPT, '0, '0);

    // Random phases. Each starts idle: drain, let any ignored item finish,
    // then program a new threshold and idling mix.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        0:       thr = 16'sh8000;          // nothing can abort
        1:       thr = 16'sh7FFF;          // nearly everything aborts
        2:       thr = '0;
        3:       thr = ABORT_BELOW_RESET;
        default: thr = 16'($urandom_range(0, 3072) - 1536);
      endcase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= thr;
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      cur_thr = thr;
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      base = n_offered;
      while (n_offered < base + ITEMS_PER_PHASE) begin
        // long receiver hold-off while items keep coming
        if (ph == 5 && !hold_done && n_offered >= base + 30) begin
          hold_reqs++;
          hold_done = 1'b1;
        end
        // sender goes quiet until every result is out
        if (ph == 6 && !drain_done && n_offered >= base + 50) begin
          drain();
          drain_done = 1'b1;
        end
        random_run();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Offered %0d items, checked %0d results: %0d succeeded, %0d aborted, %0d preempted.",
             n_offered, checked, n_succeeded, n_aborted, n_preempted);
    $display("Covered %0d thresholds with both extremes, four idle mixes, a long hold-off.",
             PHASES);
    if (mismatches == 0 && waiting == 0)
      $display("running_mean_stddev_goal test passed");
    else
      $display("running_mean_stddev_goal test failed");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
sv/rmsd_pkg.sv
sv/rmsd_if.sv
sv/rmsd_iter.sv
sv/running_mean_stddev_goal.sv
verif/rmsd_stats_checker.sv
verif/tb_top.sv
